// File: rtl/htbd_pkg.sv
// Shared types and constants for the table-driven prefix-code decoder.
package htbd_pkg;

    localparam logic [1:0] CMD_LOAD  = 2'd0;
    localparam logic [1:0] CMD_DATA  = 2'd1;
    localparam logic [1:0] CMD_FLUSH = 2'd2;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_NOMATCH = 2'd1;
    localparam logic [1:0] ST_SHORT   = 2'd2;
    localparam logic [1:0] ST_BADLEN  = 2'd3;

    localparam logic [0:0] CFG_NUM_CODES    = 1'd0;
    localparam logic [0:0] CFG_SYMBOL_TOTAL = 1'd1;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [7:0]  entry_index;
        logic [7:0]  entry_symbol;
        logic [5:0]  entry_length;
        logic [31:0] entry_code;
        logic [7:0]  data_byte;
    } in_item_t;

    typedef struct packed {
        logic [7:0] symbol;
        logic       last;
        logic [1:0] status;
    } out_item_t;

    // Controller to datapath commands.
    typedef struct packed {
        logic load_entry;   // write the table slot and update longest length
        logic append_byte;  // shift the input byte into the buffer
        logic scan_start;   // reset the match search
        logic scan_step;    // examine the entry read last cycle
        logic consume;      // remove the best match and count it
        logic fail;         // no match: mark done, drop the buffer
        logic clear;        // end of stream: clear buffer and counters
    } dp_cmd_t;

    // Datapath to controller status.
    typedef struct packed {
        logic can_decode;   // not done, below total, bits present
        logic window_ok;    // enough bits, or padding allowed
        logic scan_end;     // last entry has been examined
        logic found;        // a match was recorded
        logic reach_total;  // the next symbol completes the stream
        logic short_stream; // stream not done and below total
        logic data_ok;      // a data byte would be appended
    } dp_stat_t;

endpackage

// File: rtl/htbd_if.sv
// Valid/ready channel interface carrying one payload.
interface htbd_if #(
    parameter int W = 8
) (
);
    logic         valid;
    logic         ready;
    logic [W-1:0] payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

// File: rtl/htbd_datapath.sv
// Datapath: code table memory, bit buffer, counters and match search.
module htbd_datapath
    import htbd_pkg::*;
#(
    parameter int TABLE_DEPTH  = 256,
    parameter int MAX_CODE_LEN = 32
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            cfg_we,
    input  logic [0:0]      cfg_idx,
    input  logic [31:0]     cfg_data,
    input  in_item_t        item,
    input  logic            pad,
    input  dp_cmd_t         cmd,
    output dp_stat_t        stat,
    output logic [7:0]      best_symbol
);
    localparam int AW   = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int LW   = $clog2(MAX_CODE_LEN + 1);
    localparam int BW   = MAX_CODE_LEN + 7;
    localparam int CW   = $clog2(BW + 1);
    localparam int NW   = AW + 1;
    localparam int EW   = 8 + LW + MAX_CODE_LEN;

    logic [EW-1:0] mem [TABLE_DEPTH];
    logic [EW-1:0] rd_reg;

    logic [8:0]    num_codes_reg;
    logic [31:0]   symbol_total_reg;
    logic [LW-1:0] longest_reg, longest_next;
    logic [BW-1:0] buf_reg, buf_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [31:0]   dec_reg, dec_next;
    logic          done_reg, done_next;

    logic [NW-1:0] scan_reg, scan_next;
    logic          found_reg, found_next;
    logic [LW-1:0] best_len_reg, best_len_next;
    logic [7:0]    best_sym_reg, best_sym_next;

    logic [NW-1:0] limit;
    logic [NW-1:0] rd_ptr;
    logic [LW-1:0] e_len;
    logic [MAX_CODE_LEN-1:0] e_code;
    logic [7:0]    e_sym;
    logic [BW+MAX_CODE_LEN-1:0] win;
    logic [CW-1:0] wcnt;
    logic [BW+MAX_CODE_LEN-1:0] shifted;
    logic [MAX_CODE_LEN-1:0] lmask;
    logic          match;
    logic [LW-1:0] ld_len;
    logic          ld_in_range;
    logic          prev_valid_reg;
    logic [NW-1:0] prev_idx_reg;

    assign ld_len = LW'(item.entry_length);
    // Drop loads aimed past the end of the table.
    assign ld_in_range = {2'b00, item.entry_index} < 10'(TABLE_DEPTH);
    assign limit = (num_codes_reg > 9'(TABLE_DEPTH)) ? NW'(TABLE_DEPTH)
                                                     : NW'(num_codes_reg);
    assign rd_ptr = cmd.scan_start ? '0 : scan_reg;

    // Table memory: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (cmd.load_entry && ld_in_range)
        begin
            mem[item.entry_index[AW-1:0]] <= {item.entry_symbol, ld_len,
                MAX_CODE_LEN'(item.entry_code) &
                ((MAX_CODE_LEN'(1) << ld_len) - MAX_CODE_LEN'(1))};
        end
        rd_reg <= mem[rd_ptr[AW-1:0]];
    end

    assign {e_sym, e_len, e_code} = rd_reg;

    // Window: buffer padded up to the longest length when it holds fewer bits.
    always_comb
    begin
        win  = {{MAX_CODE_LEN{1'b0}}, buf_reg};
        wcnt = cnt_reg;
        if (CW'(longest_reg) > cnt_reg)
        begin
            win  = win << (CW'(longest_reg) - cnt_reg);
            wcnt = CW'(longest_reg);
        end
        shifted = win >> (wcnt - CW'(e_len));
        lmask   = (e_len >= LW'(MAX_CODE_LEN)) ? '1
                  : ((MAX_CODE_LEN'(1) << e_len) - MAX_CODE_LEN'(1));
        match = prev_valid_reg && (e_len != '0) && (CW'(e_len) <= wcnt)
                && (!found_reg || e_len < best_len_reg)
                && ((MAX_CODE_LEN'(shifted) & lmask) == e_code);
    end

    always_comb
    begin
        scan_next     = scan_reg;
        found_next    = found_reg;
        best_len_next = best_len_reg;
        best_sym_next = best_sym_reg;
        if (cmd.scan_start)
        begin
            scan_next  = NW'(1);
            found_next = 1'b0;
        end
        else if (cmd.scan_step)
        begin
            scan_next = scan_reg + NW'(1);
            if (match)
            begin
                found_next    = 1'b1;
                best_len_next = e_len;
                best_sym_next = e_sym;
            end
        end
    end

    always_comb
    begin
        longest_next = longest_reg;
        buf_next     = buf_reg;
        cnt_next     = cnt_reg;
        dec_next     = dec_reg;
        done_next    = done_reg;
        if (cmd.load_entry && ld_in_range && ld_len > longest_reg)
            longest_next = ld_len;
        if (cmd.append_byte)
        begin
            buf_next = {buf_reg[BW-9:0], item.data_byte};
            cnt_next = cnt_reg + CW'(8);
        end
        if (cmd.consume)
        begin
            dec_next = dec_reg + 32'd1;
            if (dec_next >= symbol_total_reg)
                done_next = 1'b1;
            if (CW'(best_len_reg) >= cnt_reg)
            begin
                cnt_next = '0;
                buf_next = '0;
            end
            else
            begin
                cnt_next = cnt_reg - CW'(best_len_reg);
                buf_next = buf_reg & ((BW'(1) << cnt_next) - BW'(1));
            end
        end
        if (cmd.fail)
        begin
            done_next = 1'b1;
            buf_next  = '0;
            cnt_next  = '0;
        end
        if (cmd.clear)
        begin
            buf_next     = '0;
            cnt_next     = '0;
            dec_next     = '0;
            longest_next = '0;
            done_next    = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_codes_reg    <= 9'd1;
            symbol_total_reg <= '0;
            longest_reg      <= '0;
            buf_reg          <= '0;
            cnt_reg          <= '0;
            dec_reg          <= '0;
            done_reg         <= 1'b0;
            scan_reg         <= '0;
            found_reg        <= 1'b0;
            prev_valid_reg   <= 1'b0;
            prev_idx_reg     <= '0;
        end
        else
        begin
            if (cfg_we && cfg_idx == CFG_NUM_CODES)
                num_codes_reg <= cfg_data[8:0];
            if (cfg_we && cfg_idx == CFG_SYMBOL_TOTAL)
                symbol_total_reg <= cfg_data;
            longest_reg    <= longest_next;
            buf_reg        <= buf_next;
            cnt_reg        <= cnt_next;
            dec_reg        <= dec_next;
            done_reg       <= done_next;
            scan_reg       <= scan_next;
            found_reg      <= found_next;
            prev_idx_reg   <= rd_ptr;
            prev_valid_reg <= (cmd.scan_start || cmd.scan_step) && (rd_ptr < limit);
        end
    end

    always_ff @(posedge clk)
    begin
        best_len_reg <= best_len_next;
        best_sym_reg <= best_sym_next;
    end

    assign stat.can_decode   = !done_reg && (dec_reg < symbol_total_reg) && (cnt_reg != '0);
    assign stat.window_ok    = pad || (cnt_reg >= CW'(longest_reg));
    assign stat.scan_end     = (prev_idx_reg + NW'(1) >= limit) || !prev_valid_reg;
    assign stat.found        = found_reg;
    assign stat.reach_total  = (dec_reg + 32'd1) >= symbol_total_reg;
    assign stat.short_stream = !done_reg && (dec_reg < symbol_total_reg);
    assign stat.data_ok      = !done_reg && (dec_reg < symbol_total_reg);
    assign best_symbol       = best_sym_reg;
endmodule

// File: rtl/htbd_ctrl.sv
// Controller: sequences loads, byte appends, table scans and results.
module htbd_ctrl
    import htbd_pkg::*;
#(
    parameter int MAX_CODE_LEN = 32
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  in_item_t   item,
    output in_item_t   item_hold,
    output logic       pad,
    output dp_cmd_t    cmd,
    input  dp_stat_t   stat,
    input  logic [7:0] best_symbol,
    output logic       out_valid,
    input  logic       out_ready,
    output out_item_t  out_item
);
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_CHECK = 3'd1;
    localparam logic [2:0] S_SCAN  = 3'd2;
    localparam logic [2:0] S_EMIT  = 3'd3;
    localparam logic [2:0] S_FLUSH = 3'd4;
    localparam logic [2:0] S_WAIT  = 3'd5;

    logic [2:0]  state_reg, state_next;
    in_item_t    hold_reg;
    logic        pad_reg, pad_next;
    logic        ov_reg, ov_next;
    out_item_t   oi_reg, oi_next;
    logic        take;
    logic        oslot;

    assign take      = in_valid && in_ready;
    assign oslot     = !ov_reg || out_ready;
    assign in_ready  = (state_reg == S_IDLE) && oslot;
    assign item_hold = hold_reg;
    assign pad       = pad_reg;
    assign out_valid = ov_reg;
    assign out_item  = oi_reg;

    always_comb
    begin
        state_next = state_reg;
        pad_next   = pad_reg;
        ov_next    = ov_reg && !out_ready;
        oi_next    = oi_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (take)
                begin
                    case (item.cmd)
                        CMD_LOAD:
                        begin
                            if (item.entry_length == 6'd0 ||
                                item.entry_length > 6'(MAX_CODE_LEN))
                            begin
                                ov_next = 1'b1;
                                oi_next = '{symbol: 8'd0, last: 1'b0, status: ST_BADLEN};
                            end
                            else
                                state_next = S_WAIT;
                        end
                        CMD_DATA:
                        begin
                            if (stat.data_ok)
                            begin
                                cmd.append_byte = 1'b1;
                                pad_next        = 1'b0;
                                state_next      = S_CHECK;
                            end
                        end
                        CMD_FLUSH:
                        begin
                            pad_next   = 1'b1;
                            state_next = S_CHECK;
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_WAIT:
            begin
                cmd.load_entry = 1'b1;
                state_next     = S_IDLE;
            end
            S_CHECK:
            begin
                if (stat.can_decode && stat.window_ok)
                begin
                    cmd.scan_start = 1'b1;
                    state_next     = S_SCAN;
                end
                else if (pad_reg)
                    state_next = S_FLUSH;
                else
                    state_next = S_IDLE;
            end
            S_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (stat.scan_end)
                    state_next = S_EMIT;
            end
            S_EMIT:
            begin
                // The scan overran by one read; that read was flagged invalid and is never matched.
                if (oslot)
                begin
                    ov_next = 1'b1;
                    if (stat.found)
                    begin
                        cmd.consume = 1'b1;
                        oi_next = '{symbol: best_symbol, last: stat.reach_total,
                                    status: ST_OK};
                    end
                    else
                    begin
                        cmd.fail = 1'b1;
                        oi_next = '{symbol: 8'd0, last: 1'b1, status: ST_NOMATCH};
                    end
                    state_next = S_CHECK;
                end
            end
            S_FLUSH:
            begin
                if (oslot)
                begin
                    if (stat.short_stream)
                    begin
                        ov_next = 1'b1;
                        oi_next = '{symbol: 8'd0, last: 1'b1, status: ST_SHORT};
                    end
                    cmd.clear  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            pad_reg   <= 1'b0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            pad_reg   <= pad_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        oi_reg <= oi_next;
        if (take)
            hold_reg <= item;
    end
endmodule

// File: rtl/huffman_table_bitstream_decoder.sv
// Sequence: a load is written from the held copy in a wait state, or returns a BADLEN
// result when its length is rejected; a data byte is appended in its transfer cycle, then
// each symbol takes a check, a scan of num_codes entries (capped at TABLE_DEPTH), one per
// cycle from a registered memory port, and an emit. A flush adds a flush step, and an output
// stall holds emit and flush until the result slot frees; a byte gives up to eight symbols.
// Reset (rst_n, asynchronous, active low) clears buffer, counters, longest length and
// the registers num_codes = 1, symbol_total = 0; the code table is undefined until loaded.
module huffman_table_bitstream_decoder
    import htbd_pkg::*;
#(
    parameter int TABLE_DEPTH  = 256,
    parameter int MAX_CODE_LEN = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    htbd_if.sink        in_ch,
    htbd_if.source      out_ch,
    input  logic        cfg_we,
    input  logic [0:0]  cfg_idx,
    input  logic [31:0] cfg_data
);
    in_item_t  item;
    in_item_t  item_hold;
    out_item_t out_item;
    dp_cmd_t   cmd;
    dp_stat_t  stat;
    logic      pad;
    logic [7:0] best_symbol;
    in_item_t  dp_item;

    assign item = in_item_t'(in_ch.payload);
    assign out_ch.payload = out_item;

    // Loads are written in the cycle after the transfer, from the held copy;
    // data bytes are appended in the transfer cycle itself.
    always_comb
    begin
        dp_item = cmd.append_byte ? item : item_hold;
    end

    htbd_ctrl #(
        .MAX_CODE_LEN (MAX_CODE_LEN)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_ch.valid),
        .in_ready    (in_ch.ready),
        .item        (item),
        .item_hold   (item_hold),
        .pad         (pad),
        .cmd         (cmd),
        .stat        (stat),
        .best_symbol (best_symbol),
        .out_valid   (out_ch.valid),
        .out_ready   (out_ch.ready),
        .out_item    (out_item)
    );

    htbd_datapath #(
        .TABLE_DEPTH  (TABLE_DEPTH),
        .MAX_CODE_LEN (MAX_CODE_LEN)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_idx     (cfg_idx),
        .cfg_data    (cfg_data),
        .item        (dp_item),
        .pad         (pad),
        .cmd         (cmd),
        .stat        (stat),
        .best_symbol (best_symbol)
    );
endmodule

// File: bench/huffman_table_bitstream_decoder_tb.sv
// Testbench for the table-driven prefix-code decoder: random and directed streams, scoreboard check.
`timescale 1ns / 1ps

module huffman_table_bitstream_decoder_tb;
    import htbd_pkg::*;

    localparam int DEPTH    = 256;
    localparam int CODE_MAX = 32;
    localparam int SETTLE   = 300;   // longer than any result-free item takes

    // Shadow decoder: table, buffer and counters, plus the queue of pending results.
    class decode_scoreboard;
        bit [7:0]    slot_sym[DEPTH];
        bit [5:0]    slot_len[DEPTH];
        bit [31:0]   slot_code[DEPTH];
        int unsigned n_codes = 1;
        int unsigned sym_total = 0;
        int unsigned longest = 0;
        bit [63:0]   held_bits = '0;
        int unsigned held_count = 0;
        int unsigned decoded = 0;
        bit          done = 0;
        out_item_t   pending[$];
        int          errors = 0;

        function bit [63:0] low_bits(int unsigned n);
            if (n >= 64)
                return '1;
            return (64'd1 << n) - 64'd1;
        endfunction

        function void add_result(bit [7:0] sym, bit lst, bit [1:0] st);
            out_item_t r;
            r.symbol = sym;
            r.last   = lst;
            r.status = st;
            pending.push_back(r);
        endfunction

        function int shortest_match(bit [63:0] win, int unsigned cnt);
            int unsigned lim;
            int          best;
            int unsigned best_len;
            lim = (n_codes > DEPTH) ? DEPTH : n_codes;
            best = -1;
            best_len = 64;
            for (int i = 0; i < lim; i++) begin
                if (slot_len[i] == 0 || slot_len[i] > cnt || slot_len[i] >= best_len)
                    continue;
                if (((win >> (cnt - slot_len[i])) & low_bits(slot_len[i])) == slot_code[i]) begin
                    best = i;
                    best_len = slot_len[i];
                end
            end
            return best;
        endfunction

        function void decode_symbols(bit pad);
            bit [63:0]   win;
            int unsigned cnt;
            int          hit;
            int unsigned len;
            while (!done && decoded < sym_total && held_count > 0) begin
                win = held_bits;
                cnt = held_count;
                if (cnt < longest) begin
                    if (!pad)
                        break;
                    win = win << (longest - cnt);
                    cnt = longest;
                end
                hit = shortest_match(win, cnt);
                if (hit < 0) begin
                    add_result(8'd0, 1'b1, ST_NOMATCH);
                    done = 1;
                    held_bits = '0;
                    held_count = 0;
                    break;
                end
                len = slot_len[hit];
                if (len >= held_count) begin
                    held_count = 0;
                    held_bits = '0;
                end
                else begin
                    held_count -= len;
                    held_bits &= low_bits(held_count);
                end
                decoded++;
                if (decoded >= sym_total) begin
                    done = 1;
                    add_result(slot_sym[hit], 1'b1, ST_OK);
                end
                else
                    add_result(slot_sym[hit], 1'b0, ST_OK);
            end
        endfunction

        function void set_config(int unsigned codes, int unsigned total);
            n_codes = codes;
            sym_total = total;
        endfunction

        function void note_input(in_item_t it);
            case (it.cmd)
                CMD_LOAD: begin
                    if (it.entry_length == 0 || it.entry_length > CODE_MAX)
                        add_result(8'd0, 1'b0, ST_BADLEN);
                    else begin
                        slot_sym[it.entry_index]  = it.entry_symbol;
                        slot_len[it.entry_index]  = it.entry_length;
                        slot_code[it.entry_index] = it.entry_code & low_bits(it.entry_length);
                        if (it.entry_length > longest)
                            longest = it.entry_length;
                    end
                end
                CMD_DATA: begin
                    if (!done && decoded < sym_total) begin
                        held_bits = ((held_bits << 8) | it.data_byte) & low_bits(held_count + 8);
                        held_count += 8;
                        decode_symbols(1'b0);
                    end
                end
                CMD_FLUSH: begin
                    decode_symbols(1'b1);
                    if (!done && decoded < sym_total)
                        add_result(8'd0, 1'b1, ST_SHORT);
                    held_bits = '0;
                    held_count = 0;
                    decoded = 0;
                    longest = 0;
                    done = 0;
                end
                default: ;
            endcase
        endfunction

        function void check_result(out_item_t got);
            out_item_t want;
            if (pending.size() == 0) begin
                $display("%0t unexpected result: expected none, actual %h/%b/%0d",
                         $realtime, got.symbol, got.last, got.status);
                errors++;
                return;
            end
            want = pending.pop_front();
            if (got.symbol !== want.symbol) begin
                $display("%0t symbol: expected %h, actual %h", $realtime, want.symbol, got.symbol);
                errors++;
            end
            if (got.last !== want.last) begin
                $display("%0t last: expected %b, actual %b", $realtime, want.last, got.last);
                errors++;
            end
            if (got.status !== want.status) begin
                $display("%0t status: expected %0d, actual %0d", $realtime, want.status, got.status);
                errors++;
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [0:0]  cfg_idx;
    logic [31:0] cfg_data;

    htbd_if #(.W($bits(in_item_t)))  in_if ();
    htbd_if #(.W($bits(out_item_t))) out_if ();

    huffman_table_bitstream_decoder u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_ch    (in_if),
        .out_ch   (out_if),
        .cfg_we   (cfg_we),
        .cfg_idx  (cfg_idx),
        .cfg_data (cfg_data)
    );

    decode_scoreboard sb = new;

    int burst_left = 0;   // transfers still due in the current sender burst
    int sent = 0;
    int rx_mode = 0;
    int rx_cycle = 0;

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Hard stop in case the block hangs.
    initial
    begin
        #(12.0 * 20_000_000);
        $display("TB_ERROR");
        $finish;
    end

    // Receiver: switch among three stall behaviors; mode 0 never stalls.
    always @(negedge clk)
    begin
        if (rx_cycle % 256 == 0)
            rx_mode = $urandom_range(0, 2);
        rx_cycle++;
        case (rx_mode)
            0: out_if.ready <= 1'b1;
            1: out_if.ready <= ($urandom_range(0, 3) != 0);
            default: out_if.ready <= ($urandom_range(0, 3) == 0);
        endcase
    end

    // Compare every result transfer against the oldest pending expectation.
    always @(posedge clk)
    begin
        if (rst_n && out_if.valid && out_if.ready)
            sb.check_result(out_if.payload);
    end

    // Send one item; called at a falling edge, returns at a falling edge.
    task automatic send_item(in_item_t it);
        if (burst_left == 0) begin
            // End of burst: drop valid for a random gap, then start a new burst.
            in_if.valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(negedge clk);
            burst_left = $urandom_range(1, 20);
        end
        in_if.payload <= it;
        in_if.valid   <= 1'b1;
        do
            @(posedge clk);
        while (!in_if.ready);
        sb.note_input(it);
        sent++;
        burst_left--;
        @(negedge clk);
    endtask

    // Hold off until every expected result has arrived and the block has settled.
    task automatic drain_block();
        in_if.valid <= 1'b0;
        burst_left = 0;
        while (sb.pending.size() != 0)
            @(negedge clk);
        repeat (SETTLE) @(negedge clk);
    endtask

    // Write both registers on consecutive cycles; the block must be idle.
    task automatic write_config(int unsigned codes, int unsigned total);
        drain_block();
        cfg_we   <= 1'b1;
        cfg_idx  <= CFG_NUM_CODES;
        cfg_data <= codes;
        @(negedge clk);
        cfg_idx  <= CFG_SYMBOL_TOTAL;
        cfg_data <= total;
        @(negedge clk);
        cfg_we   <= 1'b0;
        sb.set_config(codes, total);
    endtask

    task automatic load_entry(int idx, int sym, int len, int unsigned code);
        in_item_t it;
        it = '0;
        it.cmd          = CMD_LOAD;
        it.entry_index  = idx;
        it.entry_symbol = sym;
        it.entry_length = len;
        it.entry_code   = code;
        it.data_byte    = $urandom;
        send_item(it);
    endtask

    task automatic data_byte(int b);
        in_item_t it;
        it = '0;
        it.cmd         = CMD_DATA;
        it.data_byte   = b;
        it.entry_code  = $urandom;
        it.entry_index = $urandom;
        send_item(it);
    endtask

    task automatic other_cmd(logic [1:0] c);
        in_item_t it;
        it = '0;
        it.cmd = c;
        send_item(it);
    endtask

    initial
    begin
        int L;
        int n;
        int pick;
        int unsigned total;
        in_if.valid   = 1'b0;
        in_if.payload = '0;
        out_if.ready  = 1'b0;
        cfg_we   = 1'b0;
        cfg_idx  = CFG_NUM_CODES;
        cfg_data = '0;
        rst_n    = 1'b0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: small prefix code, bad lengths, unknown command, short stream.
        write_config(4, 6);
        load_entry(0, 8'h41, 1, 32'h0);
        load_entry(1, 8'h42, 2, 32'h2);
        load_entry(2, 8'h43, 3, 32'h6);
        load_entry(3, 8'hFF, 3, 32'hFFFF_FFFF);   // bits above the length are dropped
        load_entry(4, 8'h00, 0, 32'h0);           // zero length is rejected
        load_entry(5, 8'h11, CODE_MAX + 1, 32'h1);
        load_entry(6, 8'h22, 63, 32'hFFFF_FFFF);
        data_byte(8'b0110_1110);
        other_cmd(2'd3);                          // unknown command is dropped
        other_cmd(CMD_FLUSH);
        // Longest code, highest slot; decoding now waits for 32 buffered bits.
        load_entry(255, 8'hFF, CODE_MAX, 32'hFFFF_FFFF);
        load_entry(0, 8'h5A, CODE_MAX, 32'h8000_0001);
        data_byte(8'h80);
        data_byte(8'h00);
        data_byte(8'h00);
        data_byte(8'h01);
        data_byte(8'h00);
        data_byte(8'hFF);
        other_cmd(CMD_FLUSH);
        // No table length after flush, then patterns that the short codes decode.
        data_byte(8'hAA);
        data_byte(8'hFF);                         // decodes two symbols and completes the stream
        other_cmd(CMD_FLUSH);                     // flush of a finished stream only clears

        // Random phases.
        while (sent < 290) begin
            pick = $urandom_range(0, 9);
            if (pick == 0) begin
                // Wide or empty table range: no scan may touch unwritten slots,
                // so only loads, bytes that are ignored or match no entry, and a flush.
                case ($urandom_range(0, 3))
                    0: write_config(0, $urandom_range(0, 3));
                    1: write_config(DEPTH, 0);
                    2: write_config(511, 0);
                    default: write_config(300, 0);
                endcase
                repeat ($urandom_range(1, 4))
                    load_entry($urandom, $urandom, $urandom_range(0, 63), $urandom);
                repeat ($urandom_range(0, 3))
                    data_byte($urandom);
                other_cmd(CMD_FLUSH);
            end
            else begin
                case ($urandom_range(0, 9))
                    0: total = 0;
                    1: total = 32'hFFFF_FFFF;
                    default: total = $urandom_range(1, 40);
                endcase
                if (pick < 7) begin
                    // Complete fixed-length code with random symbols.
                    L = $urandom_range(1, 4);
                    n = 1 << L;
                    write_config(n, total);
                    for (int i = 0; i < n; i++)
                        load_entry(i, $urandom, L, i | ($urandom << L));
                end
                else begin
                    // Arbitrary short codes: no-match results become likely.
                    n = $urandom_range(1, 12);
                    write_config(n, total);
                    for (int i = 0; i < n; i++)
                        load_entry(i, $urandom, $urandom_range(1, 8), $urandom);
                end
                if ($urandom_range(0, 3) == 0)
                    load_entry($urandom_range(n, 255), $urandom,
                               $urandom_range(1, CODE_MAX), $urandom);
                if ($urandom_range(0, 5) == 0)
                    other_cmd(2'd3);
                repeat ($urandom_range(1, 8))
                    data_byte($urandom);
                if ($urandom_range(0, 9) != 0)
                    other_cmd(CMD_FLUSH);
            end
        end

        drain_block();
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
